// ----- hdl/xcfd_pkg.sv -----
// Shared constants for the XOR-checked frame deframer.
package xcfd_pkg;

  // Default depth of the payload store.
  localparam int MAX_PAYLOAD_DEF = 31;

  // Largest payload length that the 5-bit length fields can carry.
  localparam logic [4:0] LEN_SAT = 5'd31;

  // Result status codes.
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

endpackage

// ----- hdl/xor_checked_frame_deframer_top.sv -----
// Deframer for a byte stream of XOR-checked, length-prefixed frames.
//
// Input channel (in_valid, in_stall, in_byte) takes one stream byte per
// transaction. A frame is a start byte, an event id, a length byte, the
// payload and an XOR checksum. Result channel (out_valid, out_stall, out_*)
// gives one transaction per payload byte of a good frame, or a single one
// for an empty frame, a checksum mismatch or a length above the limit.
// cfg_we and cfg_wdata write max_length; write it only while idle.
// Bytes are taken at one per cycle while in_stall is low. An error or
// empty-frame result is loaded into the output register on the edge that
// takes the byte causing it. A good checksum on a non-empty frame starts
// the emit phase: the input stalls until all frame_length store entries
// are read into the output register, one per cycle while that register
// is free; that read port sets the run rate. A stalled result holds its
// output register; in the length and checksum phases intake also waits
// while the register cannot take a new result.
// Reset returns to expecting a start byte and sets max_length to 31; the
// payload store is not cleared and needs no clearing pass.
module xor_checked_frame_deframer_top #(
  parameter int MAX_PAYLOAD = xcfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_event_id,
  output logic [4:0] out_payload_length,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_has_payload,
  output logic       out_last
);

  // Store depth never exceeds what the 5-bit length field can address.
  localparam int DEPTH  = (MAX_PAYLOAD < 31) ? MAX_PAYLOAD : 31;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0] CAP = 5'(DEPTH);

  // Phase codes.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SUM   = 3'd4;
  localparam logic [2:0] PH_EMIT  = 3'd5;

  logic [4:0] max_length_r;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] event_id_r, event_id_nxt;
  logic [4:0] frame_length_r, frame_length_nxt;
  logic [4:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [4:0] emit_idx_r, emit_idx_nxt;

  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_event_id_r;
  logic [4:0] out_payload_length_r;
  logic [4:0] out_byte_index_r;
  logic [7:0] out_payload_byte_r;
  logic       out_has_payload_r;
  logic       out_last_r;

  logic [7:0] mem [DEPTH];

  logic       in_acc;
  logic       out_free;
  logic [4:0] limit;
  logic       mem_we;
  logic       res_load;
  logic       emit_load;
  logic [1:0] res_status;
  logic [4:0] res_length;
  logic       emit_last;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (phase_r == PH_EMIT) ||
                    (((phase_r == PH_LEN) || (phase_r == PH_SUM)) && !out_free);
  assign in_acc   = in_valid && !in_stall;
  assign limit    = (max_length_r > CAP) ? CAP : max_length_r;

  assign emit_load = (phase_r == PH_EMIT) && out_free;
  assign emit_last = ((emit_idx_r + 5'd1) == frame_length_r);

  // Phase sequencing and per-byte bookkeeping.
  always_comb begin
    phase_nxt        = phase_r;
    event_id_nxt     = event_id_r;
    frame_length_nxt = frame_length_r;
    bytes_seen_nxt   = bytes_seen_r;
    xor_nxt          = xor_r;
    emit_idx_nxt     = emit_idx_r;
    mem_we           = 1'b0;
    res_load         = 1'b0;
    res_status       = xcfd_pkg::ST_GOOD;
    res_length       = 5'd0;
    if (emit_load) begin
      emit_idx_nxt = emit_idx_r + 5'd1;
      if (emit_last) begin
        phase_nxt = PH_START;
      end
    end else if (in_acc) begin
      case (phase_r)
        PH_ID: begin
          event_id_nxt = in_byte;
          xor_nxt      = xor_r ^ in_byte;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          if (in_byte > {3'd0, limit}) begin
            res_load   = 1'b1;
            res_status = xcfd_pkg::ST_LEN;
            res_length = (in_byte > {3'd0, xcfd_pkg::LEN_SAT}) ? xcfd_pkg::LEN_SAT
                                                               : in_byte[4:0];
            phase_nxt  = PH_START;
          end else begin
            frame_length_nxt = in_byte[4:0];
            xor_nxt          = xor_r ^ in_byte;
            bytes_seen_nxt   = 5'd0;
            phase_nxt        = (in_byte[4:0] == 5'd0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          mem_we         = (bytes_seen_r < CAP);
          xor_nxt        = xor_r ^ in_byte;
          bytes_seen_nxt = bytes_seen_r + 5'd1;
          if (bytes_seen_nxt >= frame_length_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          if (in_byte != xor_r) begin
            res_load   = 1'b1;
            res_status = xcfd_pkg::ST_SUM;
            res_length = frame_length_r;
            phase_nxt  = PH_START;
          end else if (frame_length_r == 5'd0) begin
            res_load   = 1'b1;
            res_status = xcfd_pkg::ST_GOOD;
            res_length = 5'd0;
            phase_nxt  = PH_START;
          end else begin
            emit_idx_nxt = 5'd0;
            phase_nxt    = PH_EMIT;
          end
        end
        default: begin
          xor_nxt   = in_byte;
          phase_nxt = PH_ID;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r   <= xcfd_pkg::LEN_SAT;
      phase_r        <= PH_START;
      event_id_r     <= 8'd0;
      frame_length_r <= 5'd0;
      bytes_seen_r   <= 5'd0;
      xor_r          <= 8'd0;
      emit_idx_r     <= 5'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_length_r <= cfg_wdata;
      end
      phase_r        <= phase_nxt;
      event_id_r     <= event_id_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      xor_r          <= xor_nxt;
      emit_idx_r     <= emit_idx_nxt;
      if (res_load || emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload store write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bytes_seen_r[ADDR_W-1:0]] <= in_byte;
    end
  end

  // Output register; the store read at the current run index is registered here.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_status_r         <= xcfd_pkg::ST_GOOD;
      out_event_id_r       <= event_id_r;
      out_payload_length_r <= frame_length_r;
      out_byte_index_r     <= emit_idx_r;
      out_payload_byte_r   <= mem[emit_idx_r[ADDR_W-1:0]];
      out_has_payload_r    <= 1'b1;
      out_last_r           <= emit_last;
    end else if (res_load) begin
      out_status_r         <= res_status;
      out_event_id_r       <= event_id_r;
      out_payload_length_r <= res_length;
      out_byte_index_r     <= 5'd0;
      out_payload_byte_r   <= 8'd0;
      out_has_payload_r    <= 1'b0;
      out_last_r           <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_event_id       = out_event_id_r;
  assign out_payload_length = out_payload_length_r;
  assign out_byte_index     = out_byte_index_r;
  assign out_payload_byte   = out_payload_byte_r;
  assign out_has_payload    = out_has_payload_r;
  assign out_last           = out_last_r;

`ifndef SYNTH
  // A payload byte only ever comes from a good frame.
  a_payload_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_has_payload_r |-> out_status_r == xcfd_pkg::ST_GOOD)
    else $error("payload result with error status");

  // The run index stays inside the frame while the store is being read.
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EMIT |-> emit_idx_r < frame_length_r)
    else $error("payload run index past frame length");

  // A result that is not the last of its run means the run is still going.
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> phase_r == PH_EMIT)
    else $error("non-last result without an open payload run");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the XOR-checked frame deframer.
`timescale 1ns / 100ps

module tb_top;

  // Receive phases of the frame predictor.
  typedef enum logic [2:0] {
    WAIT_START,
    WAIT_ID,
    WAIT_LEN,
    WAIT_DATA,
    WAIT_SUM
  } frame_phase_t;

  // One result transaction, field by field.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] event_id;
    logic [4:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       last;
  } frame_result_t;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_event_id;
  logic [4:0] out_payload_length;
  logic [4:0] out_byte_index;
  logic [7:0] out_payload_byte;
  logic       out_has_payload;
  logic       out_last;

  // Predictor state and the results it still expects.
  frame_phase_t  frame_phase;
  logic [7:0]    cur_event_id;
  logic [4:0]    cur_length;
  int            data_count;
  logic [7:0]    xor_acc;
  logic [7:0]    payload_mem [xcfd_pkg::MAX_PAYLOAD_DEF];
  logic [4:0]    max_len_reg;
  frame_result_t expected_results [$];

  int   error_count = 0;
  int   bytes_accepted = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_active = 1'b0;
  event hold_off_ev;

  xor_checked_frame_deframer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_event_id       (out_event_id),
    .out_payload_length (out_payload_length),
    .out_byte_index     (out_byte_index),
    .out_payload_byte   (out_payload_byte),
    .out_has_payload    (out_has_payload),
    .out_last           (out_last)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor reset state, matching the block after reset.
  task automatic deframer_model_reset();
    frame_phase  = WAIT_START;
    cur_event_id = '0;
    cur_length   = '0;
    data_count   = 0;
    xor_acc      = '0;
    max_len_reg  = xcfd_pkg::LEN_SAT;
  endtask

  // Queue one expected result for the frame being received.
  function automatic void push_frame_result(logic [1:0] status, logic [4:0] plen,
                                            logic [4:0] idx, logic [7:0] pbyte,
                                            logic has, logic last);
    frame_result_t r;
    r.status         = status;
    r.event_id       = cur_event_id;
    r.payload_length = plen;
    r.byte_index     = idx;
    r.payload_byte   = pbyte;
    r.has_payload    = has;
    r.last           = last;
    expected_results.push_back(r);
  endfunction

  // Advance the frame predictor by one accepted stream byte.
  function automatic void deframe_byte(logic [7:0] b);
    int lim;
    int i;
    lim = (max_len_reg > xcfd_pkg::MAX_PAYLOAD_DEF) ? xcfd_pkg::MAX_PAYLOAD_DEF
                                                    : int'(max_len_reg);
    case (frame_phase)
      WAIT_ID: begin
        cur_event_id = b;
        xor_acc      = xor_acc ^ b;
        frame_phase  = WAIT_LEN;
      end
      WAIT_LEN: begin
        if (b > lim) begin
          // Oversized length reports the length saturated to five bits.
          push_frame_result(xcfd_pkg::ST_LEN,
                            (b > xcfd_pkg::LEN_SAT) ? xcfd_pkg::LEN_SAT : b[4:0],
                            '0, '0, 1'b0, 1'b1);
          frame_phase = WAIT_START;
        end else begin
          cur_length  = b[4:0];
          xor_acc     = xor_acc ^ b;
          data_count  = 0;
          frame_phase = (cur_length == 0) ? WAIT_SUM : WAIT_DATA;
        end
      end
      WAIT_DATA: begin
        if (data_count < xcfd_pkg::MAX_PAYLOAD_DEF) payload_mem[data_count] = b;
        xor_acc    = xor_acc ^ b;
        data_count = data_count + 1;
        if (data_count >= cur_length) frame_phase = WAIT_SUM;
      end
      WAIT_SUM: begin
        if (b != xor_acc) begin
          push_frame_result(xcfd_pkg::ST_SUM, cur_length, '0, '0, 1'b0, 1'b1);
        end else if (cur_length == 0) begin
          push_frame_result(xcfd_pkg::ST_GOOD, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < cur_length && i < xcfd_pkg::MAX_PAYLOAD_DEF; i++) begin
            push_frame_result(xcfd_pkg::ST_GOOD, cur_length, i[4:0], payload_mem[i],
                              1'b1, (i + 1 == cur_length));
          end
        end
        frame_phase = WAIT_START;
      end
      default: begin
        xor_acc     = b;
        frame_phase = WAIT_ID;
      end
    endcase
  endfunction

  // Offer one byte with random gaps and predict once the transaction completes.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    bytes_accepted++;
  endtask

  // Send one frame; a negative fill value means random payload bytes.
  task automatic send_frame(input logic [7:0] start_b, input logic [7:0] id_b,
                            input logic [7:0] len_b, input int fill_val,
                            input bit corrupt);
    logic [7:0] frame_q [$];
    logic [7:0] sum;
    logic [7:0] p;
    int i;
    // Fill with random bytes until the stream is back at a start byte.
    while (frame_phase != WAIT_START) send_byte(8'($urandom_range(0, 255)));
    frame_q = '{start_b, id_b, len_b};
    sum = start_b ^ id_b ^ len_b;
    // A rejected length ends the frame after the length byte.
    if (len_b <= max_len_reg) begin
      for (i = 0; i < len_b; i++) begin
        p = (fill_val < 0) ? 8'($urandom_range(0, 255)) : fill_val[7:0];
        frame_q.push_back(p);
        sum = sum ^ p;
      end
      frame_q.push_back(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    end
    foreach (frame_q[k]) send_byte(frame_q[k]);
  endtask

  // Let the sender rest until every expected result has been taken.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_length while the block is idle.
  task automatic set_max_length(input logic [4:0] v);
    wait_for_results();
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    max_len_reg  = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Field extremes and each error and empty-frame case at the reset limit.
  task automatic test_directed_frames();
    send_frame(8'h00, 8'hFF, 8'd0, -1, 1'b0);
    send_frame(8'hFF, 8'h00, 8'd1, 8'hFF, 1'b0);
    send_frame(8'hA5, 8'h5A, 8'd2, -1, 1'b1);
    send_frame(8'h12, 8'h34, 8'd0, -1, 1'b1);
    send_frame(8'h3C, 8'h81, 8'hFF, -1, 1'b0);
    send_frame(8'hC3, 8'h7E, 8'd32, -1, 1'b0);
  endtask

  // Frames on both sides of several max_length settings, extremes included.
  task automatic test_length_limits();
    set_max_length(5'd0);
    send_frame(8'h01, 8'h10, 8'd0, -1, 1'b0);
    send_frame(8'h02, 8'h20, 8'd1, -1, 1'b0);
    set_max_length(5'd31);
    send_frame(8'h03, 8'h30, 8'd31, -1, 1'b0);
    send_frame(8'h04, 8'h40, 8'd31, 8'h00, 1'b1);
    set_max_length(5'd13);
    send_frame(8'h05, 8'h50, 8'd13, -1, 1'b0);
    send_frame(8'h06, 8'h60, 8'd14, -1, 1'b0);
  endtask

  // Mostly well-formed frames with random content, plus noise and bad frames.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_bytes);
    int first;
    int len;
    int r;
    int cap;
    set_max_length(5'($urandom_range(6, 31)));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    first = bytes_accepted;
    while (bytes_accepted - first < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Stray bytes that knock the stream out of frame.
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        cap = (max_len_reg < 8) ? int'(max_len_reg) : 8;
        r = $urandom_range(0, 99);
        if (r < 5)       len = $urandom_range(32, 255);
        else if (r < 15) len = $urandom_range(0, 31);
        else             len = $urandom_range(0, cap);
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len[7:0],
                   -1, ($urandom_range(0, 99) < 10));
      end
    end
  endtask

  // Hold the output off long enough that the block backs up into its input.
  task automatic test_output_hold_off();
    set_max_length(5'd31);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_off_ev;
    repeat (6) send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'd6, -1, 1'b0);
    wait_for_results();
  endtask

  // Long receiver hold-off, counted in its own process.
  always begin
    @(hold_off_ev);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    out_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare one field of a result transaction.
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction, event_id %0d", out_event_id);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("event_id", want.event_id, out_event_id);
        check_field("payload_length", 8'(want.payload_length), 8'(out_payload_length));
        check_field("byte_index", 8'(want.byte_index), 8'(out_byte_index));
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("has_payload", 8'(want.has_payload), 8'(out_has_payload));
        check_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  // Test sequence.
  initial begin
    deframer_model_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_length_limits();
    test_random_traffic(0, 0, 40);
    test_random_traffic(74, 0, 40);
    test_random_traffic(0, 74, 40);
    test_random_traffic(17, 17, 40);
    test_output_hold_off();
    wait_for_results();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
